FILE: rtl/core/moving_average_deadband_input_defines.svh
// Assertion macros used by the moving average filter checker.
`ifndef MOVING_AVERAGE_DEADBAND_INPUT_DEFINES_SVH
`define MOVING_AVERAGE_DEADBAND_INPUT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define MAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define MAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mad_pkg.sv
// Package: types, constants and register indexes of the moving average filter.
`default_nettype none
package mad_pkg;

    localparam int SAMPLE_BITS      = 10;
    localparam int MAX_READINGS_DEF = 16;

    localparam int NUM_READINGS_W = 5;
    localparam int INTERVAL_W     = 16;
    localparam int THRESHOLD_W    = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int DIFF_W = (SAMPLE_BITS > THRESHOLD_W) ? SAMPLE_BITS : THRESHOLD_W;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_READINGS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

    localparam logic [NUM_READINGS_W-1:0] NUM_READINGS_RST     = 5'd8;
    localparam logic [INTERVAL_W-1:0]     INTERVAL_TICKS_RST   = 16'd10;
    localparam logic [THRESHOLD_W-1:0]    CHANGE_THRESHOLD_RST = 10'd4;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ACK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_WRITE,
        ST_SUM,
        ST_DIV,
        ST_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                   func;
        logic [SAMPLE_BITS-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   has_new_value;
        logic                   sample_taken;
    } t_out_req;

endpackage
`default_nettype wire

FILE: rtl/core/moving_average_deadband_input.sv
// Moving average filter with deadband: converter samples averaged over a window.
//
// One request in, one request out. An acknowledge request or a tick that takes
// no sample goes straight to the output register. The first tick after reset
// writes the sample into every window entry, one entry a cycle. For a tick
// that takes a sample, the window memory is read one entry a cycle through its
// single read port to form the sum of n entries, n being the effective window
// length, in SUM_W = SAMPLE_BITS + clog2(MAX_READINGS) (14 by default) bits;
// then a restoring divider produces one quotient bit a cycle. A finished
// result waits in the output register while the next request is taken.
// Configuration writes are always accepted and take effect at once.
`default_nettype none
module moving_average_deadband_input #(
    parameter int MAX_READINGS = mad_pkg::MAX_READINGS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  mad_pkg::t_in_req                i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output mad_pkg::t_out_req               o_out_data,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [mad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [mad_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SB    = mad_pkg::SAMPLE_BITS;
    localparam int AW    = $clog2(MAX_READINGS);
    localparam int NW    = $clog2(MAX_READINGS + 1);
    localparam int CW    = (NW > mad_pkg::NUM_READINGS_W) ? NW : mad_pkg::NUM_READINGS_W;
    localparam int RW    = NW + 1;
    localparam int SUMW  = SB + AW;
    localparam int BW    = $clog2(SUMW);
    localparam int DW    = mad_pkg::DIFF_W;
    localparam int IVW   = mad_pkg::INTERVAL_W;

    mad_pkg::t_state r_state, n_state;

    logic [mad_pkg::NUM_READINGS_W-1:0] r_num;
    logic [IVW-1:0]                     r_interval;
    logic [mad_pkg::THRESHOLD_W-1:0]    r_threshold;

    logic [SB-1:0]   r_reported, n_reported;
    logic            r_flag, n_flag;
    logic            r_primed, n_primed;
    logic [IVW-1:0]  r_elapsed, n_elapsed;
    logic [AW-1:0]   r_wp, n_wp;
    logic            r_out_valid, n_out_valid;
    logic            r_rvalid, n_rvalid;

    mad_pkg::t_out_req r_out_data, n_out_data;
    logic [SB-1:0]   r_sample, n_sample;
    logic            r_taken, n_taken;
    logic [NW-1:0]   r_idx, n_idx;
    logic [SUMW-1:0] r_acc, n_acc;
    logic [SUMW-1:0] r_mdiv, n_mdiv;
    logic [RW-1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_mrem, n_mrem;
    logic [BW-1:0]   r_bit, n_bit;
    logic [SB-1:0]   r_rdata;

    logic [SB-1:0]   r_mem [MAX_READINGS];

    logic [CW-1:0]   w_num_ext;
    logic [NW-1:0]   w_len;
    logic            w_issue;
    logic [IVW-1:0]  w_elapsed_inc;
    logic [RW-1:0]   w_rsh, w_rnext, w_msh, w_mnext;
    logic            w_qbit, w_mge;
    logic [SB-1:0]   w_avg, w_diff;
    logic            w_we;
    logic [AW-1:0]   w_waddr;

    assign o_in_stall  = (r_state != mad_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_num_ext = CW'(r_num);
        if (w_num_ext == '0) begin
            w_len = NW'(1);
        end else if (w_num_ext > CW'(MAX_READINGS)) begin
            w_len = NW'(MAX_READINGS);
        end else begin
            w_len = NW'(w_num_ext);
        end
    end

    assign w_issue       = (r_idx < w_len);
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + IVW'(1);

    assign w_rsh   = {r_rem[RW-2:0], r_acc[SUMW-1]};
    assign w_qbit  = (w_rsh >= RW'(w_len));
    assign w_rnext = w_qbit ? w_rsh - RW'(w_len) : w_rsh;
    assign w_msh   = {r_mrem[RW-2:0], r_mdiv[SUMW-1]};
    assign w_mge   = (w_msh >= RW'(w_len));
    assign w_mnext = w_mge ? w_msh - RW'(w_len) : w_msh;

    assign w_avg  = r_acc[SB-1:0];
    assign w_diff = (w_avg >= r_reported) ? w_avg - r_reported : r_reported - w_avg;

    always_comb begin
        n_state     = r_state;
        n_reported  = r_reported;
        n_flag      = r_flag;
        n_primed    = r_primed;
        n_elapsed   = r_elapsed;
        n_wp        = r_wp;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_sample    = r_sample;
        n_taken     = r_taken;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_mdiv      = r_mdiv;
        n_rem       = r_rem;
        n_mrem      = r_mrem;
        n_bit       = r_bit;
        n_rvalid    = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_wp;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mad_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_in_data.sample;
                    n_taken  = 1'b0;
                    if (i_in_data.func == mad_pkg::FUNC_ACK) begin
                        n_flag  = 1'b0;
                        n_state = mad_pkg::ST_DONE;
                    end else if (!r_primed) begin
                        n_reported = i_in_data.sample;
                        n_elapsed  = '0;
                        n_primed   = 1'b1;
                        n_idx      = '0;
                        n_state    = mad_pkg::ST_FILL;
                    end else if (w_elapsed_inc >= r_interval) begin
                        n_elapsed = '0;
                        n_taken   = 1'b1;
                        n_state   = mad_pkg::ST_WRITE;
                    end else begin
                        n_elapsed = w_elapsed_inc;
                        n_state   = mad_pkg::ST_DONE;
                    end
                end
            end
            mad_pkg::ST_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                n_idx   = r_idx + NW'(1);
                if (r_idx == NW'(MAX_READINGS - 1)) begin
                    n_state = mad_pkg::ST_DONE;
                end
            end
            mad_pkg::ST_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_wp;
                n_idx   = '0;
                n_acc   = '0;
                n_state = mad_pkg::ST_SUM;
            end
            mad_pkg::ST_SUM: begin
                if (w_issue) begin
                    n_idx    = r_idx + NW'(1);
                    n_rvalid = 1'b1;
                end
                if (r_rvalid) begin
                    n_acc = r_acc + SUMW'(r_rdata);
                end
                if (!w_issue && !r_rvalid) begin
                    n_rem   = '0;
                    n_mrem  = '0;
                    n_mdiv  = SUMW'(r_wp) + SUMW'(1);
                    n_bit   = '0;
                    n_state = mad_pkg::ST_DIV;
                end
            end
            mad_pkg::ST_DIV: begin
                n_acc  = {r_acc[SUMW-2:0], w_qbit};
                n_rem  = w_rnext;
                n_mdiv = {r_mdiv[SUMW-2:0], 1'b0};
                n_mrem = w_mnext;
                n_bit  = r_bit + BW'(1);
                if (r_bit == BW'(SUMW - 1)) begin
                    n_state = mad_pkg::ST_CMP;
                end
            end
            mad_pkg::ST_CMP: begin
                n_wp = r_mrem[AW-1:0];
                if (DW'(w_diff) > DW'(r_threshold)) begin
                    n_reported = w_avg;
                    n_flag     = 1'b1;
                end
                n_state = mad_pkg::ST_DONE;
            end
            mad_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_data.value           = r_reported;
                    n_out_data.has_new_value   = r_flag;
                    n_out_data.sample_taken    = r_taken;
                    n_state                    = mad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mad_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mad_pkg::ST_IDLE;
            r_reported  <= '0;
            r_flag      <= 1'b0;
            r_primed    <= 1'b0;
            r_elapsed   <= '0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
            r_rvalid    <= 1'b0;
            r_num       <= mad_pkg::NUM_READINGS_RST;
            r_interval  <= mad_pkg::INTERVAL_TICKS_RST;
            r_threshold <= mad_pkg::CHANGE_THRESHOLD_RST;
        end else begin
            r_state     <= n_state;
            r_reported  <= n_reported;
            r_flag      <= n_flag;
            r_primed    <= n_primed;
            r_elapsed   <= n_elapsed;
            r_wp        <= n_wp;
            r_out_valid <= n_out_valid;
            r_rvalid    <= n_rvalid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mad_pkg::REG_NUM_READINGS: begin
                        r_num <= i_cfg_data[mad_pkg::NUM_READINGS_W-1:0];
                    end
                    mad_pkg::REG_INTERVAL_TICKS: begin
                        r_interval <= i_cfg_data[IVW-1:0];
                    end
                    mad_pkg::REG_CHANGE_THRESHOLD: begin
                        r_threshold <= i_cfg_data[mad_pkg::THRESHOLD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_sample   <= n_sample;
        r_taken    <= n_taken;
        r_idx      <= n_idx;
        r_acc      <= n_acc;
        r_mdiv     <= n_mdiv;
        r_rem      <= n_rem;
        r_mrem     <= n_mrem;
        r_bit      <= n_bit;
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_sample;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

endmodule
`default_nettype wire

FILE: rtl/core/mad_checker.sv
// Port checker for the moving average filter, bound to the top level.
`default_nettype none
`include "moving_average_deadband_input_defines.svh"
module mad_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             o_in_stall,
    input  wire                             o_out_valid,
    input  wire                             i_out_stall,
    input  mad_pkg::t_out_req               o_out_data,
    input  wire                             i_cfg_valid,
    input  wire                             o_cfg_ready
);

    logic w_in_acc;
    logic w_cfg_acc;
    logic w_out_wait;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_wait = o_out_valid && i_out_stall;

    // output request held while stalled
    `MAD_ASSERT_NEXT(a_out_hold, w_out_wait, o_out_valid && $stable(o_out_data), "output changed")

    // one request in flight: input stalls right after an accept
    `MAD_ASSERT_NEXT(a_one_in_flight, w_in_acc, o_in_stall, "input accepted while busy")

    // a result only appears while a request is being worked on
    `MAD_ASSERT_NOW(a_out_from_work, $rose(o_out_valid), $past(o_in_stall), "result from no request")

    // config writes never block, even mid request
    `MAD_ASSERT_NOW(a_cfg_open, i_cfg_valid && o_in_stall, w_cfg_acc, "config write refused")

endmodule

bind moving_average_deadband_input mad_checker u_mad_checker (.*);
`default_nettype wire
